// File: rtl/core/bfha_pkg.sv
package bfha_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_mark;
    typedef logic [2:0] t_fld;

    // Request kinds.
    localparam t_kind K_ALLOC  = 2'd0;
    localparam t_kind K_FREE   = 2'd1;
    localparam t_kind K_RESIZE = 2'd2;

    // Result status codes.
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_REFUSED = 2'd1;
    localparam t_status ST_BAD     = 2'd2;

    // Boundary tag marks.
    localparam t_mark MK_NONE = 2'd0;
    localparam t_mark MK_FREE = 2'd1;
    localparam t_mark MK_USED = 2'd2;
    localparam t_mark MK_TAIL = 2'd3;

    // Tag entry field selects for a read-modify-write.
    localparam t_fld F_MARK  = 3'd0;
    localparam t_fld F_PAGES = 3'd1;
    localparam t_fld F_PRV   = 3'd2;
    localparam t_fld F_NXT   = 3'd3;
    localparam t_fld F_LPRV  = 3'd4;

    // Bytes of block header in front of the user area.
    localparam int HDR_BYTES = 12;

endpackage

// File: rtl/core/bfha_tag_ram.sv
module bfha_tag_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 46
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data is registered and holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

// File: rtl/core/best_fit_heap_allocator.sv
// Page-granular heap allocator with boundary tags and a LIFO free list. Each request
// (allocate, free or resize) is taken as one input transfer and answers with exactly one
// output transfer carrying the user address, a status and the free and low-water byte
// counts. All block tags and free-list links live in one single-port-read, single-port-
// write tag memory, and a sequencer performs every tag change as a read followed by a
// write of the same entry, one entry at a time, so no two accesses ever overlap. An
// allocation walks the free list, reading the tags of the listed blocks one by one, then
// either takes the chosen block whole or splits it and relinks the remainder; a free
// merges the block with each free neighbor it has before pushing it on the list; a
// growing resize is an allocation followed by a free.
// After reset the block writes the initial tag layout to every entry and takes
// no request until that pass is over; the fit policy register may be written at any time
// the block is idle, including during that pass. A new request is taken while the previous
// result still waits at the output register.
module best_fit_heap_allocator #(
    parameter int HEAP_PAGES = 1024,
    parameter int PAGE_SHIFT = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bfha_pkg::t_kind    i_kind,
    input  logic [15:0]        i_request_bytes,
    input  logic [14:0]        i_block_address,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [14:0]        o_result_address,
    output bfha_pkg::t_status  o_status,
    output logic [14:0]        o_free_bytes,
    output logic [14:0]        o_low_water_bytes
);
    import bfha_pkg::*;

    localparam int PW  = $clog2(HEAP_PAGES + 1);   // page numbers, sizes, links (with null)
    localparam int XW  = PW + 1;                   // page sums before the bounds check
    localparam int AIW = $clog2(HEAP_PAGES);       // tag memory index
    localparam int NW  = 17;                       // pages needed by a 16-bit request
    localparam int CW  = ((XW > NW) ? XW : NW) + 1;
    localparam int OW  = PW + PAGE_SHIFT;
    localparam int DW  = ((OW > 16) ? OW : 16) + 1;
    localparam int AW  = ((OW + 1) > 15) ? (OW + 1) : 15;
    localparam int FBW = PW + PAGE_SHIFT;
    localparam int EW  = 2 + 4 * PW;

    localparam logic [PW-1:0]  LINK_NIL  = PW'(HEAP_PAGES);
    localparam logic [AIW-1:0] LAST_PAGE = AIW'(HEAP_PAGES - 1);
    localparam logic [FBW-1:0] INIT_FREE = FBW'((HEAP_PAGES - 2) << PAGE_SHIFT);

    typedef struct packed {
        logic [1:0]    mark;
        logic [PW-1:0] pages;
        logic [PW-1:0] prv;
        logic [PW-1:0] nxt;
        logic [PW-1:0] lprv;
    } t_ent;

    localparam logic [1:0] M_ALLOC  = 2'd0;
    localparam logic [1:0] M_FREE   = 2'd1;
    localparam logic [1:0] M_RESIZE = 2'd2;
    localparam logic [1:0] M_GROW   = 2'd3;

    localparam logic [5:0] S_IDLE   = 6'd0;
    localparam logic [5:0] S_CLR    = 6'd1;
    localparam logic [5:0] S_CHK    = 6'd2;
    localparam logic [5:0] S_DONE   = 6'd3;
    localparam logic [5:0] S_UWR    = 6'd4;
    localparam logic [5:0] S_SH1    = 6'd5;
    localparam logic [5:0] S_SH2    = 6'd6;
    localparam logic [5:0] S_SH3    = 6'd7;
    localparam logic [5:0] S_SH4    = 6'd8;
    localparam logic [5:0] S_SH5    = 6'd9;
    localparam logic [5:0] S_WSTART = 6'd10;
    localparam logic [5:0] S_WISSUE = 6'd11;
    localparam logic [5:0] S_WCHK   = 6'd12;
    localparam logic [5:0] S_WEND   = 6'd13;
    localparam logic [5:0] S_TK1    = 6'd14;
    localparam logic [5:0] S_TK2    = 6'd15;
    localparam logic [5:0] S_TK3    = 6'd16;
    localparam logic [5:0] S_TK4    = 6'd17;
    localparam logic [5:0] S_TK5    = 6'd18;
    localparam logic [5:0] S_TK6    = 6'd19;
    localparam logic [5:0] S_TK7    = 6'd20;
    localparam logic [5:0] S_TK8    = 6'd21;
    localparam logic [5:0] S_TK9    = 6'd22;
    localparam logic [5:0] S_GR0    = 6'd23;
    localparam logic [5:0] S_GR1    = 6'd24;
    localparam logic [5:0] S_REL0   = 6'd25;
    localparam logic [5:0] S_REL1   = 6'd26;
    localparam logic [5:0] S_REL2   = 6'd27;
    localparam logic [5:0] S_REL3   = 6'd28;
    localparam logic [5:0] S_REL4   = 6'd29;
    localparam logic [5:0] S_REL5   = 6'd30;
    localparam logic [5:0] S_REL6   = 6'd31;
    localparam logic [5:0] S_REL7   = 6'd32;
    localparam logic [5:0] S_REL8   = 6'd33;
    localparam logic [5:0] S_REL9   = 6'd34;
    localparam logic [5:0] S_REL10  = 6'd35;
    localparam logic [5:0] S_REL11  = 6'd36;
    localparam logic [5:0] S_PU1    = 6'd37;
    localparam logic [5:0] S_PU2    = 6'd38;
    localparam logic [5:0] S_PU3    = 6'd39;
    localparam logic [5:0] S_PU4    = 6'd40;
    localparam logic [5:0] S_RM0    = 6'd41;
    localparam logic [5:0] S_RM1    = 6'd42;
    localparam logic [5:0] S_RM2    = 6'd43;
    localparam logic [5:0] S_RM3    = 6'd44;
    localparam logic [5:0] S_RM4    = 6'd45;

    // Control state.
    logic [5:0]     r_st, n_st, r_ret, n_ret, r_pret, n_pret, r_rret, n_rret;
    logic [AIW-1:0] r_clr, n_clr;
    logic [PW-1:0]  r_head, n_head;
    logic [FBW-1:0] r_fbc, n_fbc, r_low, n_low;
    logic           r_pol, n_pol;
    logic           r_ovalid, n_ovalid;

    // Working registers of the current request.
    logic [1:0]     r_mode, n_mode;
    logic [15:0]    r_req, n_req;
    logic [14:0]    r_addr, n_addr;
    logic [NW-1:0]  r_need, n_need;
    logic [PW-1:0]  r_p, n_p, r_psize, n_psize, r_pprev, n_pprev, r_old, n_old;
    logic [PW-1:0]  r_n, n_n, r_steps, n_steps, r_fit, n_fit, r_fitsz, n_fitsz;
    logic [PW-1:0]  r_q, n_q, r_qsize, n_qsize, r_msize, n_msize;
    logic [XW-1:0]  r_nx, n_nx, r_after, n_after;
    logic [PW-1:0]  r_parg, n_parg, r_rarg, n_rarg, r_lnx, n_lnx, r_lpv, n_lpv;
    logic [PW-1:0]  r_uaddr, n_uaddr, r_uval, n_uval;
    t_fld           r_ufld, n_ufld;
    logic [14:0]    r_res, n_res;
    t_status        r_stat, n_stat;
    logic [14:0]    r_ores, n_ores, r_ofree, n_ofree, r_olow, n_olow;
    t_status        r_ostat, n_ostat;

    // Tag memory port.
    logic           c_ren, c_wen;
    logic [AIW-1:0] c_raddr, c_waddr;
    logic [EW-1:0]  c_wdata, w_rdata;
    t_ent           e_rd, e_w;

    // Scheduled read-modify-write of one tag field.
    logic           u_go;
    logic [PW-1:0]  u_addr, u_val;
    t_fld           u_fld;

    // Request decode.
    logic [16:0]    d_sum;
    logic [14:0]    d_off, d_pg;
    logic           d_bad;
    logic [FBW-1:0] f_sub;
    logic [AW-1:0]  d_ua;

    bfha_tag_ram #(
        .DEPTH (HEAP_PAGES),
        .WIDTH (EW)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_rd_en   (c_ren),
        .i_rd_addr (c_raddr),
        .i_wr_en   (c_wen),
        .i_wr_addr (c_waddr),
        .i_wr_data (c_wdata),
        .o_rd_data (w_rdata)
    );

    assign e_rd = t_ent'(w_rdata);

    // The address checks that need no tag read: header offset, page alignment, range and
    // the header page itself. The used mark is checked after the tag read.
    always_comb begin
        d_sum = {1'b0, i_request_bytes} + 17'(HDR_BYTES + (1 << PAGE_SHIFT) - 1);
        d_off = i_block_address - 15'(HDR_BYTES);
        d_pg  = d_off >> PAGE_SHIFT;
        d_bad = (i_block_address < 15'(HDR_BYTES))
             || ((d_off & 15'((1 << PAGE_SHIFT) - 1)) != 15'd0)
             || (d_pg >= 15'(HEAP_PAGES))
             || (d_pg == 15'd0);
        f_sub = r_fbc - (FBW'(r_fitsz) << PAGE_SHIFT);
        d_ua  = (AW'(r_fit) << PAGE_SHIFT) + AW'(HDR_BYTES);
    end

    always_comb begin
        n_st = r_st;       n_ret = r_ret;     n_pret = r_pret;   n_rret = r_rret;
        n_clr = r_clr;     n_head = r_head;   n_fbc = r_fbc;     n_low = r_low;
        n_pol = r_pol;     n_ovalid = r_ovalid;
        n_mode = r_mode;   n_req = r_req;     n_addr = r_addr;   n_need = r_need;
        n_p = r_p;         n_psize = r_psize; n_pprev = r_pprev; n_old = r_old;
        n_n = r_n;         n_steps = r_steps; n_fit = r_fit;     n_fitsz = r_fitsz;
        n_q = r_q;         n_qsize = r_qsize; n_msize = r_msize;
        n_nx = r_nx;       n_after = r_after;
        n_parg = r_parg;   n_rarg = r_rarg;   n_lnx = r_lnx;     n_lpv = r_lpv;
        n_uaddr = r_uaddr; n_uval = r_uval;   n_ufld = r_ufld;
        n_res = r_res;     n_stat = r_stat;
        n_ores = r_ores;   n_ostat = r_ostat; n_ofree = r_ofree; n_olow = r_olow;
        c_ren = 1'b0;      c_raddr = '0;      c_wen = 1'b0;      c_waddr = '0;
        e_w = e_rd;
        u_go = 1'b0;       u_addr = '0;       u_val = '0;        u_fld = F_MARK;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end
        if (i_cfg_wr_en) begin
            n_pol = i_cfg_wr_data;
        end

        case (r_st)
            S_CLR: begin
                e_w.mark  = MK_NONE;
                e_w.pages = '0;
                e_w.prv   = '0;
                e_w.nxt   = LINK_NIL;
                e_w.lprv  = LINK_NIL;
                if (r_clr == AIW'(0)) begin
                    e_w.mark  = MK_USED;
                    e_w.pages = PW'(1);
                end else if (r_clr == AIW'(1)) begin
                    e_w.mark  = MK_FREE;
                    e_w.pages = PW'(HEAP_PAGES - 2);
                end else if (r_clr == LAST_PAGE) begin
                    e_w.mark  = MK_TAIL;
                    e_w.pages = PW'(1);
                    e_w.prv   = PW'(1);
                end
                c_wen   = 1'b1;
                c_waddr = r_clr;
                n_clr   = r_clr + AIW'(1);
                if (r_clr == LAST_PAGE) begin
                    n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req  = i_request_bytes;
                    n_addr = i_block_address;
                    n_need = NW'(d_sum >> PAGE_SHIFT);
                    n_res  = '0;
                    n_p    = PW'(d_pg);
                    if (i_kind == K_ALLOC || (i_kind == K_RESIZE && i_block_address == '0)) begin
                        n_mode = M_ALLOC;
                        if (i_request_bytes == '0) begin
                            n_stat = ST_REFUSED;
                            n_st   = S_DONE;
                        end else begin
                            n_st = S_WSTART;
                        end
                    end else if (i_kind == K_FREE || i_kind == K_RESIZE) begin
                        n_mode = (i_kind == K_FREE || i_request_bytes == '0) ? M_FREE : M_RESIZE;
                        if (d_bad) begin
                            n_stat = ST_BAD;
                            n_st   = S_DONE;
                        end else begin
                            c_ren   = 1'b1;
                            c_raddr = AIW'(d_pg);
                            n_st    = S_CHK;
                        end
                    end else begin
                        n_stat = ST_REFUSED;
                        n_st   = S_DONE;
                    end
                end
            end
            S_CHK: begin
                if (e_rd.mark != MK_USED) begin
                    n_stat = ST_BAD;
                    n_st   = S_DONE;
                end else begin
                    n_psize = e_rd.pages;
                    n_pprev = e_rd.prv;
                    n_stat  = ST_OK;
                    if (r_mode == M_FREE) begin
                        n_st = S_REL0;
                    end else if (((DW'(e_rd.pages) << PAGE_SHIFT) - DW'(HDR_BYTES))
                                 < DW'(r_req)) begin
                        n_mode = M_GROW;
                        n_old  = r_p;
                        n_st   = S_WSTART;
                    end else if (CW'(e_rd.pages) >= CW'(r_need) + CW'(1)
                                 && CW'(r_p) + CW'(r_need) < CW'(HEAP_PAGES)) begin
                        // Shrink: the tail end becomes a block of its own and is freed.
                        n_q     = PW'(CW'(r_p) + CW'(r_need));
                        n_qsize = e_rd.pages - PW'(r_need);
                        n_res   = r_addr;
                        n_st    = S_SH1;
                    end else begin
                        n_res = r_addr;
                        n_st  = S_DONE;
                    end
                end
            end
            S_SH1: begin
                u_go = 1'b1; u_addr = r_q; u_fld = F_PRV; u_val = r_p; n_ret = S_SH2;
            end
            S_SH2: begin
                u_go = 1'b1; u_addr = r_q; u_fld = F_PAGES; u_val = r_qsize; n_ret = S_SH3;
            end
            S_SH3: begin
                if (XW'(r_p) + XW'(r_psize) < XW'(HEAP_PAGES)) begin
                    u_go = 1'b1; u_addr = PW'(XW'(r_p) + XW'(r_psize));
                    u_fld = F_PRV; u_val = r_q; n_ret = S_SH4;
                end else begin
                    n_st = S_SH4;
                end
            end
            S_SH4: begin
                u_go = 1'b1; u_addr = r_p; u_fld = F_PAGES; u_val = PW'(r_need);
                n_ret = S_SH5;
            end
            S_SH5: begin
                n_pprev = r_p;
                n_p     = r_q;
                n_psize = r_qsize;
                n_st    = S_REL0;
            end
            S_WSTART: begin
                n_n     = r_head;
                n_steps = '0;
                n_fit   = LINK_NIL;
                n_fitsz = '0;
                n_st    = S_WISSUE;
            end
            S_WISSUE: begin
                if (r_n < LINK_NIL && r_steps < LINK_NIL) begin
                    c_ren   = 1'b1;
                    c_raddr = AIW'(r_n);
                    n_st    = S_WCHK;
                end else begin
                    n_st = S_WEND;
                end
            end
            S_WCHK: begin
                n_n     = e_rd.nxt;
                n_steps = r_steps + PW'(1);
                n_st    = S_WISSUE;
                if (CW'(e_rd.pages) >= CW'(r_need)) begin
                    if (!r_pol || CW'(e_rd.pages) == CW'(r_need)) begin
                        n_fit   = r_n;
                        n_fitsz = e_rd.pages;
                        n_st    = S_WEND;
                    end else if (r_fit == LINK_NIL || e_rd.pages < r_fitsz) begin
                        n_fit   = r_n;
                        n_fitsz = e_rd.pages;
                    end
                end
            end
            S_WEND: begin
                if (r_fit == LINK_NIL) begin
                    n_res  = '0;
                    n_stat = ST_REFUSED;
                    n_st   = S_DONE;
                end else if (CW'(r_fitsz) >= CW'(r_need) + CW'(1)
                             && CW'(r_fit) + CW'(r_need) < CW'(HEAP_PAGES)) begin
                    n_q     = PW'(CW'(r_fit) + CW'(r_need));
                    n_qsize = r_fitsz - PW'(r_need);
                    n_st    = S_TK1;
                end else begin
                    n_st = S_TK7;
                end
            end
            S_TK1: begin
                u_go = 1'b1; u_addr = r_q; u_fld = F_PAGES; u_val = r_qsize; n_ret = S_TK2;
            end
            S_TK2: begin
                u_go = 1'b1; u_addr = r_q; u_fld = F_MARK; u_val = PW'(MK_FREE);
                n_ret = S_TK3;
            end
            S_TK3: begin
                u_go = 1'b1; u_addr = r_q; u_fld = F_PRV; u_val = r_fit; n_ret = S_TK4;
            end
            S_TK4: begin
                u_go = 1'b1; u_addr = r_fit; u_fld = F_PAGES; u_val = PW'(r_need);
                n_ret = S_TK5;
                n_fitsz = PW'(r_need);
            end
            S_TK5: begin
                n_parg = r_q;
                n_pret = S_TK6;
                n_st   = S_PU1;
            end
            S_TK6: begin
                if (XW'(r_q) + XW'(r_qsize) < XW'(HEAP_PAGES)) begin
                    u_go = 1'b1; u_addr = PW'(XW'(r_q) + XW'(r_qsize));
                    u_fld = F_PRV; u_val = r_q; n_ret = S_TK7;
                end else begin
                    n_st = S_TK7;
                end
            end
            S_TK7: begin
                u_go = 1'b1; u_addr = r_fit; u_fld = F_MARK; u_val = PW'(MK_USED);
                n_ret = S_TK8;
            end
            S_TK8: begin
                n_rarg = r_fit;
                n_rret = S_TK9;
                n_st   = S_RM0;
            end
            S_TK9: begin
                n_fbc  = f_sub;
                n_low  = (r_low > f_sub) ? f_sub : r_low;
                n_res  = d_ua[14:0];
                n_stat = ST_OK;
                n_st   = (r_mode == M_GROW) ? S_GR0 : S_DONE;
            end
            S_GR0: begin
                // The old block's tag may have changed during the split, so read it again.
                c_ren   = 1'b1;
                c_raddr = AIW'(r_old);
                n_st    = S_GR1;
            end
            S_GR1: begin
                n_p     = r_old;
                n_psize = e_rd.pages;
                n_pprev = e_rd.prv;
                n_st    = S_REL0;
            end
            S_REL0: begin
                n_fbc = r_fbc + (FBW'(r_psize) << PAGE_SHIFT);
                n_nx  = XW'(r_p) + XW'(r_psize);
                if (r_pprev < LINK_NIL && r_pprev != r_p) begin
                    c_ren   = 1'b1;
                    c_raddr = AIW'(r_pprev);
                    n_st    = S_REL1;
                end else begin
                    n_st = S_REL5;
                end
            end
            S_REL1: begin
                if (e_rd.mark == MK_FREE) begin
                    n_msize = e_rd.pages + r_psize;
                    u_go = 1'b1; u_addr = r_pprev; u_fld = F_PAGES;
                    u_val = e_rd.pages + r_psize; n_ret = S_REL2;
                end else begin
                    n_st = S_REL5;
                end
            end
            S_REL2: begin
                if (r_nx < XW'(HEAP_PAGES)) begin
                    u_go = 1'b1; u_addr = PW'(r_nx); u_fld = F_PRV; u_val = r_pprev;
                    n_ret = S_REL3;
                end else begin
                    n_st = S_REL3;
                end
            end
            S_REL3: begin
                n_rarg = r_pprev;
                n_rret = S_REL4;
                n_st   = S_RM0;
            end
            S_REL4: begin
                u_go = 1'b1; u_addr = r_p; u_fld = F_MARK; u_val = PW'(MK_NONE);
                n_ret = S_REL5;
                n_p     = r_pprev;
                n_psize = r_msize;
            end
            S_REL5: begin
                if (r_nx < XW'(HEAP_PAGES) && r_nx != XW'(r_p)) begin
                    c_ren   = 1'b1;
                    c_raddr = AIW'(r_nx);
                    n_st    = S_REL6;
                end else begin
                    n_st = S_REL10;
                end
            end
            S_REL6: begin
                if (e_rd.mark == MK_FREE) begin
                    n_after = r_nx + XW'(e_rd.pages);
                    n_psize = r_psize + e_rd.pages;
                    u_go = 1'b1; u_addr = r_p; u_fld = F_PAGES;
                    u_val = r_psize + e_rd.pages; n_ret = S_REL7;
                end else begin
                    n_st = S_REL10;
                end
            end
            S_REL7: begin
                if (r_after < XW'(HEAP_PAGES)) begin
                    u_go = 1'b1; u_addr = PW'(r_after); u_fld = F_PRV; u_val = r_p;
                    n_ret = S_REL8;
                end else begin
                    n_st = S_REL8;
                end
            end
            S_REL8: begin
                n_rarg = PW'(r_nx);
                n_rret = S_REL9;
                n_st   = S_RM0;
            end
            S_REL9: begin
                u_go = 1'b1; u_addr = PW'(r_nx); u_fld = F_MARK; u_val = PW'(MK_NONE);
                n_ret = S_REL10;
            end
            S_REL10: begin
                u_go = 1'b1; u_addr = r_p; u_fld = F_MARK; u_val = PW'(MK_FREE);
                n_ret = S_REL11;
            end
            S_REL11: begin
                n_parg = r_p;
                n_pret = S_DONE;
                n_st   = S_PU1;
            end
            S_PU1: begin
                u_go = 1'b1; u_addr = r_parg; u_fld = F_LPRV; u_val = LINK_NIL;
                n_ret = S_PU2;
            end
            S_PU2: begin
                u_go = 1'b1; u_addr = r_parg; u_fld = F_NXT; u_val = r_head; n_ret = S_PU3;
            end
            S_PU3: begin
                if (r_head < LINK_NIL) begin
                    u_go = 1'b1; u_addr = r_head; u_fld = F_LPRV; u_val = r_parg;
                    n_ret = S_PU4;
                end else begin
                    n_st = S_PU4;
                end
            end
            S_PU4: begin
                n_head = r_parg;
                n_st   = r_pret;
            end
            S_RM0: begin
                c_ren   = 1'b1;
                c_raddr = AIW'(r_rarg);
                n_st    = S_RM1;
            end
            S_RM1: begin
                n_lnx = e_rd.nxt;
                n_lpv = e_rd.lprv;
                n_st  = S_RM2;
            end
            S_RM2: begin
                if (r_lnx < LINK_NIL) begin
                    u_go = 1'b1; u_addr = r_lnx; u_fld = F_LPRV; u_val = r_lpv;
                    n_ret = S_RM3;
                end else begin
                    n_st = S_RM3;
                end
            end
            S_RM3: begin
                if (r_lpv < LINK_NIL) begin
                    u_go = 1'b1; u_addr = r_lpv; u_fld = F_NXT; u_val = r_lnx;
                    n_ret = S_RM4;
                end else begin
                    n_st = S_RM4;
                end
            end
            S_RM4: begin
                if (r_head == r_rarg) begin
                    n_head = r_lnx;
                end
                n_st = r_rret;
            end
            S_UWR: begin
                // Second half of a tag update: merge the field into the entry just read.
                case (r_ufld)
                    F_MARK:  e_w.mark  = r_uval[1:0];
                    F_PAGES: e_w.pages = r_uval;
                    F_PRV:   e_w.prv   = r_uval;
                    F_NXT:   e_w.nxt   = r_uval;
                    F_LPRV:  e_w.lprv  = r_uval;
                    default: e_w = e_rd;
                endcase
                c_wen   = 1'b1;
                c_waddr = AIW'(r_uaddr);
                n_st    = r_ret;
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_ores   = r_res;
                    n_ostat  = r_stat;
                    n_ofree  = 15'(r_fbc);
                    n_olow   = 15'(r_low);
                    n_st     = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase

        // First half of a tag update: read the entry now, write it back in S_UWR. The
        // sequencer never issues another access in between, so no forwarding is needed.
        if (u_go) begin
            c_ren   = 1'b1;
            c_raddr = AIW'(u_addr);
            n_uaddr = u_addr;
            n_ufld  = u_fld;
            n_uval  = u_val;
            n_st    = S_UWR;
        end
    end

    assign c_wdata = e_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_ret    <= S_IDLE;
            r_pret   <= S_IDLE;
            r_rret   <= S_IDLE;
            r_clr    <= '0;
            r_head   <= PW'(1);
            r_fbc    <= INIT_FREE;
            r_low    <= INIT_FREE;
            r_pol    <= 1'b1;
            r_ovalid <= 1'b0;
            r_mode   <= M_ALLOC;
        end else begin
            r_st     <= n_st;
            r_ret    <= n_ret;
            r_pret   <= n_pret;
            r_rret   <= n_rret;
            r_clr    <= n_clr;
            r_head   <= n_head;
            r_fbc    <= n_fbc;
            r_low    <= n_low;
            r_pol    <= n_pol;
            r_ovalid <= n_ovalid;
            r_mode   <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;   r_addr  <= n_addr;  r_need  <= n_need;
        r_p     <= n_p;     r_psize <= n_psize; r_pprev <= n_pprev; r_old <= n_old;
        r_n     <= n_n;     r_steps <= n_steps; r_fit   <= n_fit;   r_fitsz <= n_fitsz;
        r_q     <= n_q;     r_qsize <= n_qsize; r_msize <= n_msize;
        r_nx    <= n_nx;    r_after <= n_after;
        r_parg  <= n_parg;  r_rarg  <= n_rarg;  r_lnx   <= n_lnx;   r_lpv <= n_lpv;
        r_uaddr <= n_uaddr; r_uval  <= n_uval;  r_ufld  <= n_ufld;
        r_res   <= n_res;   r_stat  <= n_stat;
        r_ores  <= n_ores;  r_ostat <= n_ostat; r_ofree <= n_ofree; r_olow <= n_olow;
    end

    assign o_in_stall        = (r_st != S_IDLE);
    assign o_out_valid       = r_ovalid;
    assign o_result_address  = r_ores;
    assign o_status          = r_ostat;
    assign o_free_bytes      = r_ofree;
    assign o_low_water_bytes = r_olow;

    // The low-water mark is taken after each allocation, and frees only add bytes.
    a_low_le_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_fbc)
        else $error("low-water count above free count");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fbc <= INIT_FREE)
        else $error("free count above heap size");

    a_uwr_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_UWR |-> $past(c_ren))
        else $error("tag write-back without a preceding read");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LINK_NIL)
        else $error("free-list head out of range");

endmodule
